>>> sv/bchd_pkg.sv
// Shared types and constants for the button click / hold detector.
// No dependencies; used by the lane, merge and top-level modules.
package bchd_pkg;

  localparam int BUTTONS    = 4;
  localparam int BTN_W      = 2;
  localparam int LANE_SLOTS = 4;
  localparam int SLOT_W     = $clog2(LANE_SLOTS);
  localparam int ALL_SLOTS  = BUTTONS * LANE_SLOTS;
  localparam int ALL_W      = $clog2(ALL_SLOTS);
  localparam int MAX_EVENTS = 12;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

  typedef enum logic [2:0] {
    EV_CLICK      = 3'd0,
    EV_DOUBLE     = 3'd1,
    EV_HOLD_START = 3'd2,
    EV_HOLD_TICK  = 3'd3,
    EV_HOLD_END   = 3'd4
  } kind_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [15:0] tick;
  } evt_t;

  // timing registers shared by all lanes
  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] window;
    logic [15:0] hold;
    logic [15:0] period;
  } timing_t;

  // wrap-safe deadline test
  function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

endpackage

>>> sv/button_click_hold_detector_top.sv
// Top level of the button click / hold detector: configuration registers,
// one lane per button and the merging stage. Depends on bchd_pkg, bchd_lane, bchd_merge.
//
//  channel   direction  signals
//  in        request    in_valid, in_ready, now_time, raw_levels
//  out       result     out_valid, out_ready, button_index, event_kind,
//                       tick_number, last_of_poll
//  cfg       write      cfg_we, cfg_index, cfg_data
//
// When a poll is taken, all lanes update in parallel into the slot buffer.
// The merging stage then sends one event per cycle while the output is not stalled,
// 0 to 12 events per poll, and the buffer holds the poll until then; the next poll is taken
// in the cycle its last event moves to the output register.
// Reset (synchronous) clears lane state and restores register defaults.
// A stalled output holds the result register; the buffer waits behind it.
module button_click_hold_detector_top
  import bchd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           now_time,
  input  logic [3:0]            raw_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            button_index,
  output logic [2:0]            event_kind,
  output logic [15:0]           tick_number,
  output logic                  last_of_poll,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  timing_t                              timing;
  logic [BUTTONS-1:0]                   dc_enables;
  logic [LIMIT_W-1:0]                   event_limit;
  logic [LIMIT_W-1:0]                   limit_sat;
  logic                                 take;
  evt_t [BUTTONS-1:0][LANE_SLOTS-1:0]   lane_events;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce <= 16'd20;
      timing.window   <= 16'd300;
      timing.hold     <= 16'd800;
      timing.period   <= 16'd200;
      dc_enables      <= '0;
      event_limit     <= LIMIT_W'(MAX_EVENTS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: timing.debounce <= cfg_data;
        REG_WINDOW:   timing.window   <= cfg_data;
        REG_HOLD:     timing.hold     <= cfg_data;
        REG_PERIOD:   timing.period   <= cfg_data;
        REG_ENABLES:  dc_enables      <= cfg_data[BUTTONS-1:0];
        REG_LIMIT:    event_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // limit saturates at MAX_EVENTS, below the slot count of a full poll
  assign limit_sat = (event_limit > LIMIT_W'(MAX_EVENTS)) ? LIMIT_W'(MAX_EVENTS) : event_limit;
  assign take      = in_valid && in_ready;

  // one lane per button
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    bchd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .take      (take),
      .now_time  (now_time),
      .level     (raw_levels[b]),
      .dc_enable (dc_enables[b]),
      .timing    (timing),
      .events    (lane_events[b])
    );
  end

  bchd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .lane_events  (lane_events),
    .limit        (limit_sat),
    .free         (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .event_kind   (event_kind),
    .tick_number  (tick_number),
    .last_of_poll (last_of_poll)
  );

endmodule

>>> sv/bchd_lane.sv
// One button lane: debounce, click, double click and hold tracking.
// Depends on bchd_pkg; produces up to LANE_SLOTS ordered events per request.
module bchd_lane
  import bchd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [31:0]                now_time,
  input  logic                       level,
  input  logic                       dc_enable,
  input  timing_t                    timing,
  output evt_t [LANE_SLOTS-1:0]      events
);

  logic        raw_seen, stable_level, hold_active, click_waiting, release_silenced;
  logic [31:0] raw_change_stamp, press_stamp, next_tick_stamp, click_expiry;
  logic [15:0] tick_count;

  logic        raw_seen_next, stable_level_next, hold_active_next;
  logic        click_waiting_next, release_silenced_next;
  logic [31:0] raw_change_stamp_next, press_stamp_next, next_tick_stamp_next;
  logic [31:0] click_expiry_next;
  logic [15:0] tick_count_next;

  logic        changed, elapsed, deb, deb_press, set_waiting, hold_reach, exp_reach;
  logic [31:0] since_change, press_deadline, tick_after, now_plus_period;

  // per-request state update and event slots
  always_comb begin
    raw_seen_next         = raw_seen;
    stable_level_next     = stable_level;
    hold_active_next      = hold_active;
    click_waiting_next    = click_waiting;
    release_silenced_next = release_silenced;
    raw_change_stamp_next = raw_change_stamp;
    press_stamp_next      = press_stamp;
    next_tick_stamp_next  = next_tick_stamp;
    click_expiry_next     = click_expiry;
    tick_count_next       = tick_count;
    set_waiting           = 1'b0;
    hold_reach            = 1'b0;
    exp_reach             = 1'b0;
    for (int s = 0; s < LANE_SLOTS; s++) begin
      events[s] = '{vld: 1'b0, kind: EV_CLICK, tick: 16'd0};
    end

    // debounce: a fresh change only passes when the debounce time is zero
    changed      = (level != raw_seen);
    since_change = now_time - raw_change_stamp;
    elapsed      = changed ? (timing.debounce == 16'd0)
                           : (since_change >= {16'd0, timing.debounce});
    raw_seen_next = level;
    if (changed) begin
      raw_change_stamp_next = now_time;
    end
    deb       = (level != stable_level) && elapsed;
    deb_press = deb && level;

    // debounced edge
    if (deb) begin
      stable_level_next = level;
      if (level) begin
        if (click_waiting) begin
          events[0] = '{vld: 1'b1, kind: EV_DOUBLE, tick: 16'd0};
          click_waiting_next    = 1'b0;
          release_silenced_next = 1'b1;
        end else begin
          release_silenced_next = 1'b0;
        end
        press_stamp_next = now_time;
        hold_active_next = 1'b0;
        tick_count_next  = 16'd0;
      end else begin
        if (hold_active) begin
          events[0] = '{vld: 1'b1, kind: EV_HOLD_END, tick: 16'd0};
        end else if (!release_silenced) begin
          if (dc_enable) begin
            click_waiting_next = 1'b1;
            click_expiry_next  = now_time + {16'd0, timing.window};
            set_waiting        = 1'b1;
          end else begin
            events[0] = '{vld: 1'b1, kind: EV_CLICK, tick: 16'd0};
          end
        end
        hold_active_next      = 1'b0;
        release_silenced_next = 1'b0;
      end
    end

    // hold start and hold ticks
    press_deadline  = deb_press ? now_time + {16'd0, timing.hold}
                                : press_stamp + {16'd0, timing.hold};
    now_plus_period = now_time + {16'd0, timing.period};
    tick_after      = next_tick_stamp + {16'd0, timing.period};
    if (stable_level_next) begin
      if (!hold_active_next) begin
        hold_reach = deb_press ? (timing.hold == 16'd0) : reached(now_time, press_deadline);
        if (hold_reach) begin
          hold_active_next     = 1'b1;
          click_waiting_next   = 1'b0;
          tick_count_next      = 16'd1;
          next_tick_stamp_next = press_deadline + {16'd0, timing.period};
          events[1] = '{vld: 1'b1, kind: EV_HOLD_START, tick: 16'd0};
          events[2] = '{vld: 1'b1, kind: EV_HOLD_TICK, tick: 16'd1};
        end
      end else if (reached(now_time, next_tick_stamp)) begin
        tick_count_next = tick_count + 16'd1;
        events[1] = '{vld: 1'b1, kind: EV_HOLD_TICK, tick: tick_count + 16'd1};
        // late request: restart the schedule from now
        next_tick_stamp_next = reached(now_time, tick_after) ? now_plus_period : tick_after;
      end
    end

    // double-click window ran out
    exp_reach = set_waiting ? (timing.window == 16'd0) : reached(now_time, click_expiry);
    if (click_waiting_next && exp_reach) begin
      events[3] = '{vld: 1'b1, kind: EV_CLICK, tick: 16'd0};
      click_waiting_next = 1'b0;
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen         <= 1'b0;
      stable_level     <= 1'b0;
      hold_active      <= 1'b0;
      click_waiting    <= 1'b0;
      release_silenced <= 1'b0;
      raw_change_stamp <= 32'd0;
      press_stamp      <= 32'd0;
      next_tick_stamp  <= 32'd0;
      click_expiry     <= 32'd0;
      tick_count       <= 16'd0;
    end else if (take) begin
      raw_seen         <= raw_seen_next;
      stable_level     <= stable_level_next;
      hold_active      <= hold_active_next;
      click_waiting    <= click_waiting_next;
      release_silenced <= release_silenced_next;
      raw_change_stamp <= raw_change_stamp_next;
      press_stamp      <= press_stamp_next;
      next_tick_stamp  <= next_tick_stamp_next;
      click_expiry     <= click_expiry_next;
      tick_count       <= tick_count_next;
    end
  end

endmodule

>>> sv/bchd_merge.sv
// Merging stage: holds the event slots of all lanes and sends them out in order.
// Depends on bchd_pkg; applies the per-request event limit and marks the last event.
module bchd_merge
  import bchd_pkg::*;
(
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  evt_t [BUTTONS-1:0][LANE_SLOTS-1:0]     lane_events,
  input  logic [LIMIT_W-1:0]                     limit,
  output logic                                   free,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [BTN_W-1:0]                       button_index,
  output logic [2:0]                             event_kind,
  output logic [15:0]                            tick_number,
  output logic                                   last_of_poll
);

  logic [ALL_SLOTS-1:0]  pending;
  kind_t                 kinds [ALL_SLOTS];
  logic [15:0]           ticks [ALL_SLOTS];
  logic [LIMIT_W-1:0]    sent;

  logic [ALL_W-1:0]      first;
  logic [ALL_SLOTS-1:0]  rest;
  logic                  emit, cut, last;

  // first pending slot in button order
  always_comb begin
    first = '0;
    for (int i = ALL_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        first = ALL_W'(i);
      end
    end
    rest = pending;
    rest[first] = 1'b0;
  end

  assign emit = (pending != '0) && (!out_valid || out_ready);
  assign cut  = ({1'b0, sent} + 5'd1) >= {1'b0, limit};
  assign last = cut || (rest == '0);
  assign free = (pending == '0) || (emit && last);

  // slot buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      sent    <= '0;
    end else if (load) begin
      for (int b = 0; b < BUTTONS; b++) begin
        for (int s = 0; s < LANE_SLOTS; s++) begin
          pending[b*LANE_SLOTS+s] <= lane_events[b][s].vld && (limit != '0);
        end
      end
      sent <= '0;
    end else if (emit) begin
      pending <= last ? '0 : rest;
      sent    <= sent + LIMIT_W'(1);
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int b = 0; b < BUTTONS; b++) begin
        for (int s = 0; s < LANE_SLOTS; s++) begin
          kinds[b*LANE_SLOTS+s] <= lane_events[b][s].kind;
          ticks[b*LANE_SLOTS+s] <= lane_events[b][s].tick;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      button_index <= first[ALL_W-1:SLOT_W];
      event_kind   <= kinds[first];
      tick_number  <= ticks[first];
      last_of_poll <= last;
    end
  end

endmodule
